[rtl/ecms_pkg.sv]
// Shared types and constants of the camera motion step block.
// No dependencies; used by ecms_mul and euler_camera_motion_step_top.
`default_nettype none

package ecms_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;

    // Working width of the rotated vector components.
    localparam int VEC_W = 26;

    // Angle format: Q10.6 degrees, one full turn.
    localparam int FULL_TURN = 23040;
    localparam int HALF_STEP = 11520;

    // A full turn is 45 * 512; the division by 45 uses a reciprocal.
    localparam int DIV_PRE_SHIFT = 9;
    localparam int RECIP_SHIFT   = 32;
    localparam int RECIP45       = 95443718;

    // Quarter-wave sine polynomial coefficients, Q15.
    localparam int TRIG_K1 = 51472;
    localparam int TRIG_K2 = 21024;
    localparam int TRIG_K3 = 2320;

    // Q14 unit, its half, and the number of fraction bits.
    localparam int QUARTER    = 16384;
    localparam int ROUND_HALF = 8192;
    localparam int FRAC       = 14;

    typedef enum logic [2:0] {
        CFG_DECEL   = 3'd0,
        CFG_THRESH  = 3'd1,
        CFG_PLIMIT  = 3'd2,
        CFG_START_X = 3'd3,
        CFG_START_Y = 3'd4,
        CFG_START_Z = 3'd5
    } cfg_index_t;

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_RED  = 17'h00002,
        ST_TURN = 17'h00004,
        ST_ZSQ  = 17'h00008,
        ST_K3   = 17'h00010,
        ST_A    = 17'h00020,
        ST_B    = 17'h00040,
        ST_Y    = 17'h00080,
        ST_R0   = 17'h00100,
        ST_R1   = 17'h00200,
        ST_R2   = 17'h00400,
        ST_R3   = 17'h00800,
        ST_R4   = 17'h01000,
        ST_SPD1 = 17'h02000,
        ST_SPD2 = 17'h04000,
        ST_DONE = 17'h08000,
        ST_HOLD = 17'h10000
    } state_t;

endpackage

`default_nettype wire

[rtl/ecms_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ecms_pkg for the operand and product widths.
`default_nettype none

module ecms_mul (
    input  wire                                   aclk,
    input  wire logic signed [ecms_pkg::MUL_W-1:0] mul_a,
    input  wire logic signed [ecms_pkg::MUL_W-1:0] mul_b,
    output logic signed [ecms_pkg::PROD_W-1:0]     prod
);

    logic signed [ecms_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= ecms_pkg::PROD_W'(mul_a) * ecms_pkg::PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/euler_camera_motion_step_top.sv]
// Camera motion step: sequencer, trig, rotation and motion datapath.
// Depends on ecms_pkg and instantiates ecms_mul.
`default_nettype none

// Channel  | dir | handshake             | payload
// ---------+-----+-----------------------+---------------------------------------
// s_       | in  | s_tvalid / s_tready   | s_tdata: angles and speed impulses
// m_       | out | m_tvalid / m_tready   | m_tdata: eye, view, pitch and yaw used
// cfg_     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data: register writes
//
// An accepted item passes through the sequencer before the result register loads:
// the sine and cosine of the three angles, the view rotation, the speed update,
// the speed rotation and the final state. A new item is accepted only once the
// sequencer has returned to idle after the result register loads. All products
// go through the single registered multiplier: 27 for the sine and cosine of the
// three angles and 24 for the two vector rotations.
// Reset is synchronous and active low; it restores the register defaults and
// places the eye at the origin with zero speed. A result that is not taken holds
// the sequencer in its final state; no new item is accepted until then.

module euler_camera_motion_step_top #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire          aclk,
    input  wire          aresetn,
    // s_tdata, from bit 0: pitch_deg[16], yaw_deg[16], roll_deg[16],
    // impulse_x[24], impulse_z[24]
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [95:0]  s_tdata,
    // m_tdata, from bit 0: eye_x[32], eye_y[32], eye_z[32], view_x[16],
    // view_y[16], view_z[16], pitch_used[16], yaw_used[16]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [175:0] m_tdata,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [2:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);

    localparam int MW       = ecms_pkg::MUL_W;
    localparam int PW       = ecms_pkg::PROD_W;
    localparam int VW       = ecms_pkg::VEC_W;
    localparam int NUM_W    = 16 + SINE_TABLE_BITS;
    localparam int DIVX_W   = NUM_W - ecms_pkg::DIV_PRE_SHIFT;
    localparam int TURN_PAD = 16 - SINE_TABLE_BITS;

    // Round half up at 14 fraction bits of the trig factor.
    function automatic logic signed [VW-1:0] rnd14(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v + PW'(ecms_pkg::ROUND_HALF);
        return t[ecms_pkg::FRAC +: VW];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
        logic signed [15:0] r;
        if (v > VW'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -VW'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Impulse add with saturation, then the dead band around zero.
    function automatic logic signed [23:0] speed_kick(input logic signed [23:0] s,
                                                     input logic signed [23:0] imp,
                                                     input logic [15:0] th);
        logic signed [25:0] sum;
        logic signed [25:0] th_s;
        logic signed [23:0] r;
        sum  = 26'(s) + 26'(imp);
        th_s = signed'(26'(th));
        r    = sat24(sum);
        if ((26'(r) > -th_s) && (26'(r) < th_s)) begin
            r = '0;
        end
        return r;
    endfunction

    // Deceleration: positive speeds step down, then negative ones step up.
    function automatic logic signed [23:0] speed_decel(input logic signed [23:0] s,
                                                      input logic [15:0] d);
        logic signed [25:0] t;
        logic signed [25:0] d_s;
        t   = 26'(s);
        d_s = signed'(26'(d));
        if (t > 26'sd0) begin
            t = t - d_s;
        end
        if (t < 26'sd0) begin
            t = t + d_s;
        end
        return sat24(t);
    endfunction

    function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                  input logic signed [VW-1:0] m);
        logic signed [32:0] sum;
        logic signed [31:0] r;
        sum = 33'(p) + 33'(m);
        if (sum > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (sum < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = sum[31:0];
        end
        return r;
    endfunction

    ecms_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic        [15:0] decel_reg;
    logic        [15:0] thresh_reg;
    logic        [12:0] plimit_reg;

    // Item registers and trig sequencing.
    logic signed [15:0] ang_reg [3];
    logic signed [23:0] imp_x_reg, imp_z_reg;
    logic        [1:0]  ang_idx_reg;
    logic               phase_reg;
    logic        [15:0] turn_reg;
    logic        [15:0] z_reg;
    logic        [15:0] z2_reg;
    logic        [1:0]  quad_reg;
    logic signed [15:0] sin_reg [3];
    logic signed [15:0] cos_reg [3];

    // Rotation datapath.
    logic signed [VW-1:0] vec_reg [3];
    logic        [1:0]    stage_reg;
    logic                 pass_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [VW-1:0] unew_reg;

    // Frame state and results.
    logic signed [15:0] view_reg [3];
    logic signed [23:0] spd_x_reg, spd_z_reg;
    logic signed [31:0] pos_reg [3];
    logic               m_valid_reg;
    logic      [175:0]  m_data_reg;

    // Multiplier connections.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    ecms_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // Input item fields.
    logic signed [15:0] in_pitch, in_yaw, in_roll;
    logic signed [23:0] in_imp_x, in_imp_z;
    logic signed [16:0] pitch_c, lim_s;
    logic signed [15:0] yaw_w;

    assign in_pitch = s_tdata[15:0];
    assign in_yaw   = s_tdata[31:16];
    assign in_roll  = s_tdata[47:32];
    assign in_imp_x = s_tdata[71:48];
    assign in_imp_z = s_tdata[95:72];

    always_comb begin
        lim_s = signed'(17'(plimit_reg));
        if (17'(in_pitch) > lim_s) begin
            pitch_c = lim_s;
        end else if (17'(in_pitch) < -lim_s) begin
            pitch_c = -lim_s;
        end else begin
            pitch_c = 17'(in_pitch);
        end
        if (in_yaw > 16'(ecms_pkg::FULL_TURN)) begin
            yaw_w = '0;
        end else if (in_yaw < 16'sd0) begin
            yaw_w = 16'(ecms_pkg::FULL_TURN);
        end else begin
            yaw_w = in_yaw;
        end
    end

    // Angle reduction into one turn and the numerator of the table index.
    logic signed [17:0]       red_a, red_b, red_c;
    logic        [14:0]       red_m;
    logic        [NUM_W-1:0]  num;
    logic        [DIVX_W-1:0] div_x;

    always_comb begin
        red_a = 18'(ang_reg[ang_idx_reg]);
        red_b = (red_a < 18'sd0) ? red_a + 18'(ecms_pkg::FULL_TURN) : red_a;
        red_b = (red_b < 18'sd0) ? red_b + 18'(ecms_pkg::FULL_TURN) : red_b;
        red_c = (red_b >= 18'(ecms_pkg::FULL_TURN)) ? red_b - 18'(ecms_pkg::FULL_TURN)
                                                   : red_b;
        red_m = red_c[14:0];
        num   = (NUM_W'(red_m) << SINE_TABLE_BITS) + NUM_W'(ecms_pkg::HALF_STEP);
        div_x = num[NUM_W-1:ecms_pkg::DIV_PRE_SHIFT];
    end

    // Quarter-wave sine steps.
    logic [15:0] turn_now, tt;
    logic [1:0]  quad_now;
    logic [13:0] rem_now;
    logic [16:0] zq17;
    logic [15:0] z_now;
    logic [16:0] p15;
    logic [16:0] a_val, b_val;
    logic [17:0] ysum;
    logic [15:0] y_mag;
    logic signed [15:0] y_val;

    always_comb begin
        turn_now = 16'(prod[ecms_pkg::RECIP_SHIFT +: SINE_TABLE_BITS]) << TURN_PAD;
        tt       = phase_reg ? turn_reg + 16'(ecms_pkg::QUARTER) : turn_reg;
        quad_now = tt[15:14];
        rem_now  = tt[13:0];
        zq17     = quad_now[0] ? ((17'(ecms_pkg::QUARTER) - 17'(rem_now)) << 1)
                               : (17'(rem_now) << 1);
        z_now    = zq17[15:0];
        p15      = prod[31:15];
        a_val    = 17'(ecms_pkg::TRIG_K2) - p15;
        b_val    = 17'(ecms_pkg::TRIG_K1) - p15;
        ysum     = 18'(p15) + 18'd1;
        y_mag    = ysum[16:1];
        y_val    = quad_reg[1] ? -signed'(y_mag) : signed'(y_mag);
    end

    // Operand selection for the current rotation stage.
    logic signed [VW-1:0] rot_u, rot_w;
    logic signed [15:0]   rot_s, rot_c;

    always_comb begin
        case (stage_reg)
            2'd0: begin
                rot_u = vec_reg[1];
                rot_w = vec_reg[2];
                rot_s = sin_reg[0];
                rot_c = cos_reg[0];
            end
            2'd1: begin
                rot_u = vec_reg[0];
                rot_w = vec_reg[1];
                rot_s = sin_reg[2];
                rot_c = cos_reg[2];
            end
            default: begin
                rot_u = vec_reg[2];
                rot_w = vec_reg[0];
                rot_s = sin_reg[1];
                rot_c = cos_reg[1];
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ecms_pkg::ST_RED: begin
                mul_a = MW'(div_x);
                mul_b = MW'(ecms_pkg::RECIP45);
            end
            ecms_pkg::ST_ZSQ: begin
                mul_a = MW'(z_now);
                mul_b = MW'(z_now);
            end
            ecms_pkg::ST_K3: begin
                mul_a = MW'(p15[15:0]);
                mul_b = MW'(ecms_pkg::TRIG_K3);
            end
            ecms_pkg::ST_A: begin
                mul_a = MW'(z2_reg);
                mul_b = MW'(a_val);
            end
            ecms_pkg::ST_B: begin
                mul_a = MW'(z_reg);
                mul_b = MW'(b_val);
            end
            ecms_pkg::ST_R0: begin
                mul_a = MW'(rot_u);
                mul_b = MW'(rot_c);
            end
            ecms_pkg::ST_R1: begin
                mul_a = MW'(rot_w);
                mul_b = MW'(rot_s);
            end
            ecms_pkg::ST_R2: begin
                mul_a = MW'(rot_w);
                mul_b = MW'(rot_c);
            end
            ecms_pkg::ST_R3: begin
                mul_a = MW'(rot_u);
                mul_b = MW'(rot_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ecms_pkg::ST_IDLE: if (s_tvalid) state_next = ecms_pkg::ST_RED;
            ecms_pkg::ST_RED:  state_next = ecms_pkg::ST_TURN;
            ecms_pkg::ST_TURN: state_next = ecms_pkg::ST_ZSQ;
            ecms_pkg::ST_ZSQ:  state_next = ecms_pkg::ST_K3;
            ecms_pkg::ST_K3:   state_next = ecms_pkg::ST_A;
            ecms_pkg::ST_A:    state_next = ecms_pkg::ST_B;
            ecms_pkg::ST_B:    state_next = ecms_pkg::ST_Y;
            ecms_pkg::ST_Y: begin
                if (!phase_reg) begin
                    state_next = ecms_pkg::ST_ZSQ;
                end else if (ang_idx_reg == 2'd2) begin
                    state_next = ecms_pkg::ST_R0;
                end else begin
                    state_next = ecms_pkg::ST_RED;
                end
            end
            ecms_pkg::ST_R0:   state_next = ecms_pkg::ST_R1;
            ecms_pkg::ST_R1:   state_next = ecms_pkg::ST_R2;
            ecms_pkg::ST_R2:   state_next = ecms_pkg::ST_R3;
            ecms_pkg::ST_R3:   state_next = ecms_pkg::ST_R4;
            ecms_pkg::ST_R4: begin
                if (stage_reg != 2'd2) begin
                    state_next = ecms_pkg::ST_R0;
                end else if (!pass_reg) begin
                    state_next = ecms_pkg::ST_SPD1;
                end else begin
                    state_next = ecms_pkg::ST_DONE;
                end
            end
            ecms_pkg::ST_SPD1: state_next = ecms_pkg::ST_SPD2;
            ecms_pkg::ST_SPD2: state_next = ecms_pkg::ST_R0;
            ecms_pkg::ST_DONE: if (out_free) state_next = ecms_pkg::ST_IDLE;
            ecms_pkg::ST_HOLD: state_next = ecms_pkg::ST_IDLE;
            default:           state_next = ecms_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ecms_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ecms_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ang_reg[0]  <= pitch_c[15:0];
                    ang_reg[1]  <= yaw_w;
                    ang_reg[2]  <= in_roll;
                    imp_x_reg   <= in_imp_x;
                    imp_z_reg   <= in_imp_z;
                    ang_idx_reg <= 2'd0;
                    phase_reg   <= 1'b0;
                    stage_reg   <= 2'd0;
                    pass_reg    <= 1'b0;
                    vec_reg[0]  <= '0;
                    vec_reg[1]  <= '0;
                    vec_reg[2]  <= VW'(ecms_pkg::QUARTER);
                end
            end
            ecms_pkg::ST_TURN: turn_reg <= turn_now;
            ecms_pkg::ST_ZSQ: begin
                z_reg    <= z_now;
                quad_reg <= quad_now;
            end
            ecms_pkg::ST_K3: z2_reg <= p15[15:0];
            ecms_pkg::ST_Y: begin
                if (!phase_reg) begin
                    sin_reg[ang_idx_reg] <= y_val;
                    phase_reg            <= 1'b1;
                end else begin
                    cos_reg[ang_idx_reg] <= y_val;
                    phase_reg            <= 1'b0;
                    if (ang_idx_reg != 2'd2) begin
                        ang_idx_reg <= ang_idx_reg + 2'd1;
                    end
                end
            end
            ecms_pkg::ST_R1: acc_reg <= prod;
            ecms_pkg::ST_R2: unew_reg <= rnd14(acc_reg - prod);
            ecms_pkg::ST_R3: acc_reg <= prod;
            ecms_pkg::ST_R4: begin
                case (stage_reg)
                    2'd0: begin
                        vec_reg[1] <= unew_reg;
                        vec_reg[2] <= rnd14(acc_reg + prod);
                    end
                    2'd1: begin
                        vec_reg[0] <= unew_reg;
                        vec_reg[1] <= rnd14(acc_reg + prod);
                    end
                    default: begin
                        vec_reg[2] <= unew_reg;
                        vec_reg[0] <= rnd14(acc_reg + prod);
                    end
                endcase
                stage_reg <= (stage_reg == 2'd2) ? 2'd0 : stage_reg + 2'd1;
            end
            ecms_pkg::ST_SPD1: begin
                view_reg[0] <= sat16(vec_reg[0]);
                view_reg[1] <= sat16(vec_reg[1]);
                view_reg[2] <= sat16(vec_reg[2]);
            end
            ecms_pkg::ST_SPD2: begin
                vec_reg[0] <= VW'(speed_decel(spd_x_reg, decel_reg));
                vec_reg[1] <= '0;
                vec_reg[2] <= VW'(speed_decel(spd_z_reg, decel_reg));
                pass_reg   <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Speeds are frame state and follow the reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_x_reg <= '0;
            spd_z_reg <= '0;
        end else if (state_reg == ecms_pkg::ST_SPD1) begin
            spd_x_reg <= speed_kick(spd_x_reg, imp_x_reg, thresh_reg);
            spd_z_reg <= speed_kick(spd_z_reg, imp_z_reg, thresh_reg);
        end else if (state_reg == ecms_pkg::ST_SPD2) begin
            spd_x_reg <= speed_decel(spd_x_reg, decel_reg);
            spd_z_reg <= speed_decel(spd_z_reg, decel_reg);
        end
    end

    // Configuration writes; a start write also places the eye there.
    logic done_load;
    assign done_load = (state_reg == ecms_pkg::ST_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decel_reg  <= 16'd6554;
            thresh_reg <= 16'd66;
            plimit_reg <= 13'd5440;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
        end else begin
            if (done_load) begin
                pos_reg[0] <= pos_add(pos_reg[0], vec_reg[0]);
                pos_reg[1] <= pos_add(pos_reg[1], vec_reg[1]);
                pos_reg[2] <= pos_add(pos_reg[2], vec_reg[2]);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    ecms_pkg::CFG_DECEL:   decel_reg  <= cfg_data[15:0];
                    ecms_pkg::CFG_THRESH:  thresh_reg <= cfg_data[15:0];
                    ecms_pkg::CFG_PLIMIT:  plimit_reg <= cfg_data[12:0];
                    ecms_pkg::CFG_START_X: pos_reg[0] <= cfg_data;
                    ecms_pkg::CFG_START_Y: pos_reg[1] <= cfg_data;
                    ecms_pkg::CFG_START_Z: pos_reg[2] <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register: the eye is the position before this frame's move.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_load) begin
            m_data_reg <= {ang_reg[1], ang_reg[0], view_reg[2], view_reg[1], view_reg[0],
                           pos_reg[2], pos_reg[1], pos_reg[0]};
        end
    end

    assign s_tready  = (state_reg == ecms_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ecms_pkg::ST_RED))
        else $error("accepted item did not start angle reduction");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ecms_pkg::ST_DONE && out_free) |=>
        (m_tvalid && state_reg == ecms_pkg::ST_IDLE))
        else $error("finished item not presented on the result channel");

    a_view_then_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ecms_pkg::ST_R4 && stage_reg == 2'd2 && !pass_reg) |=>
        (state_reg == ecms_pkg::ST_SPD1))
        else $error("view rotation did not hand over to the speed update");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the camera motion step block: directed and random frames,
// register writes between phases, random idling and a long output stall.
// Depends on ecms_pkg and euler_camera_motion_step_top.
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_BITS = 10;
    localparam int TURN       = 23040;
    localparam longint S24_MIN = -8388608;
    localparam longint S24_MAX = 8388607;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    typedef struct packed {
        logic signed [23:0] imp_z;
        logic signed [23:0] imp_x;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } frame_t;

    typedef struct packed {
        logic signed [15:0] yaw_used;
        logic signed [15:0] pitch_used;
        logic signed [15:0] view_z;
        logic signed [15:0] view_y;
        logic signed [15:0] view_x;
        logic signed [31:0] eye_z;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_x;
    } pose_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    euler_camera_motion_step_top #(.SINE_TABLE_BITS(TABLE_BITS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the registers and the motion state.
    longint decel, thresh, plimit;
    longint pos [3];
    longint spd_x, spd_z;

    pose_t pose_q[$];
    int    errors;
    bit    hold_output;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Round half up after dropping the 14 fraction bits (floor shift).
    function automatic longint round_q14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint quarter_wave(longint z);
        longint z2, a, b;
        z2 = (z * z) >> 15;
        a = 21024 - ((z2 * 2320) >> 15);
        b = 51472 - ((z2 * a) >> 15);
        return (z * b) >> 15;
    endfunction

    function automatic longint sine_of_turn(longint t);
        longint q, r, z, y;
        q = (t >> 14) & 3;
        r = t & 16'h3FFF;
        z = q[0] ? ((16384 - r) << 1) : (r << 1);
        y = (quarter_wave(z) + 1) >> 1;
        return q[1] ? -y : y;
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint m, idx, t;
        m = ang % TURN;
        if (m < 0) m += TURN;
        idx = ((m << TABLE_BITS) + TURN / 2) / TURN;
        idx &= (1 << TABLE_BITS) - 1;
        t = (idx << (16 - TABLE_BITS)) & 16'hFFFF;
        s = sine_of_turn(t);
        c = sine_of_turn((t + 16384) & 16'hFFFF);
    endtask

    // Rotate about X, then Z, then Y.
    task automatic rotate_xzy(inout longint v [3], input longint s [3], input longint c [3]);
        longint x, y, z, t;
        x = v[0]; y = v[1]; z = v[2];
        t = round_q14(y * c[0] - z * s[0]);
        z = round_q14(z * c[0] + y * s[0]);
        y = t;
        t = round_q14(x * c[2] - y * s[2]);
        y = round_q14(y * c[2] + x * s[2]);
        x = t;
        t = round_q14(x * c[1] + z * s[1]);
        z = round_q14(z * c[1] - x * s[1]);
        x = t;
        v[0] = x; v[1] = y; v[2] = z;
    endtask

    function automatic longint next_speed(longint s, longint imp);
        s = clip(s + imp, S24_MIN, S24_MAX);
        if (s > -thresh && s < thresh) s = 0;
        if (s > 0) s -= decel;
        if (s < 0) s += decel;
        return clip(s, S24_MIN, S24_MAX);
    endfunction

    task automatic predict_frame(input frame_t f);
        longint p, y, s [3], c [3], v [3], m [3];
        pose_t e;
        p = longint'(f.pitch);
        y = longint'(f.yaw);
        if (p > plimit) p = plimit;
        if (p < -plimit) p = -plimit;
        if (y > TURN) y = 0;
        if (y < 0) y = TURN;
        sin_cos(p, s[0], c[0]);
        sin_cos(y, s[1], c[1]);
        sin_cos(longint'(f.roll), s[2], c[2]);
        v[0] = 0; v[1] = 0; v[2] = 16384;
        rotate_xzy(v, s, c);
        e.eye_x = 32'(pos[0]);
        e.eye_y = 32'(pos[1]);
        e.eye_z = 32'(pos[2]);
        e.view_x = 16'(clip(v[0], -32768, 32767));
        e.view_y = 16'(clip(v[1], -32768, 32767));
        e.view_z = 16'(clip(v[2], -32768, 32767));
        e.pitch_used = 16'(p);
        e.yaw_used = 16'(y);
        pose_q.push_back(e);
        spd_x = next_speed(spd_x, longint'(f.imp_x));
        spd_z = next_speed(spd_z, longint'(f.imp_z));
        m[0] = spd_x; m[1] = 0; m[2] = spd_z;
        rotate_xzy(m, s, c);
        for (int i = 0; i < 3; i++) pos[i] = clip(pos[i] + m[i], S32_MIN, S32_MAX);
    endtask

    // Sends one frame after a random gap and updates the prediction on acceptance.
    // The valid line stays up after acceptance until the next gap or a stop.
    task automatic send_frame(input frame_t f, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= f;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame(f);
        @(negedge aclk);
    endtask

    // Register writes happen only when nothing is in flight.
    task automatic write_reg(input ecms_pkg::cfg_index_t idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ecms_pkg::CFG_DECEL:   decel  = val[15:0];
            ecms_pkg::CFG_THRESH:  thresh = val[15:0];
            ecms_pkg::CFG_PLIMIT:  plimit = val[12:0];
            ecms_pkg::CFG_START_X: pos[0] = longint'(signed'(val));
            ecms_pkg::CFG_START_Y: pos[1] = longint'(signed'(val));
            ecms_pkg::CFG_START_Z: pos[2] = longint'(signed'(val));
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic frame_t random_frame();
        frame_t f;
        f = {$urandom, $urandom, $urandom};
        // Mostly realistic pitch, yaw and impulses, sometimes the full range.
        if ($urandom_range(0, 3) != 0) begin
            f.pitch = 16'($signed($urandom_range(0, 12000)) - 6000);
            f.yaw   = 16'($signed($urandom_range(0, 23200)) - 80);
            f.imp_x = 24'($signed($urandom_range(0, 40000)) - 20000);
            f.imp_z = 24'($signed($urandom_range(0, 40000)) - 20000);
        end
        return f;
    endfunction

    // The receiver side: a random wait before each item, or a long hold when asked.
    initial begin : receiver
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            wait_cycles = $urandom_range(0, 11);
            if (wait_cycles > 0 || hold_output) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
                while (hold_output) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                pose_t e, a;
                e = pose_q.pop_front();
                a = m_tdata;
                if (a.eye_x !== e.eye_x)
                    $display("%0t: eye_x exp %0d got %0d", $time, e.eye_x, a.eye_x);
                if (a.eye_y !== e.eye_y)
                    $display("%0t: eye_y exp %0d got %0d", $time, e.eye_y, a.eye_y);
                if (a.eye_z !== e.eye_z)
                    $display("%0t: eye_z exp %0d got %0d", $time, e.eye_z, a.eye_z);
                if (a.view_x !== e.view_x)
                    $display("%0t: view_x exp %0d got %0d", $time, e.view_x, a.view_x);
                if (a.view_y !== e.view_y)
                    $display("%0t: view_y exp %0d got %0d", $time, e.view_y, a.view_y);
                if (a.view_z !== e.view_z)
                    $display("%0t: view_z exp %0d got %0d", $time, e.view_z, a.view_z);
                if (a.pitch_used !== e.pitch_used)
                    $display("%0t: pitch_used exp %0d got %0d", $time,
                             e.pitch_used, a.pitch_used);
                if (a.yaw_used !== e.yaw_used)
                    $display("%0t: yaw_used exp %0d got %0d", $time,
                             e.yaw_used, a.yaw_used);
                if (a !== e) errors++;
            end
        end
    end

    // Angle and impulse extremes, pitch clamp edges and yaw wrap edges.
    task automatic test_directed();
        frame_t f;
        longint pv [8] = '{32767, -32768, 5440, 5441, -5441, 0, 23040, -1};
        longint yv [8] = '{23040, 23041, -1, 0, 32767, -32768, 11520, 5760};
        for (int i = 0; i < 8; i++) begin
            f = '0;
            f.pitch = 16'(pv[i]);
            f.yaw   = 16'(yv[i]);
            f.roll  = (i % 2) ? -16'sd32768 : 16'sd32767;
            f.imp_x = (i % 3 == 0) ? 24'sh7FFFFF : 24'sh800000;
            f.imp_z = (i % 3 == 1) ? 24'sh7FFFFF : 24'sh800000;
            send_frame(f);
        end
        // Small speeds: below threshold, just above it, small negative.
        f = '0; f.imp_x = 24'shFFFFFF; f.imp_z = -24'sd8388607; send_frame(f);
        f = '0; f.imp_x = 24'sd65; f.imp_z = 24'sd70; send_frame(f);
        f = '0; f.imp_x = -24'sd70; f.imp_z = -24'sd3000; send_frame(f);
        f = '0; f.roll = 16'sd1234; f.yaw = 16'sd23039; send_frame(f);
    endtask

    // Random frames under the given register setting.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_frame(random_frame());
    endtask

    // Positions near the limits so that the move saturates.
    task automatic test_saturation();
        frame_t f;
        write_reg(ecms_pkg::CFG_START_X, 32'h7FFF_FF00);
        write_reg(ecms_pkg::CFG_START_Y, 32'h8000_0100);
        write_reg(ecms_pkg::CFG_START_Z, 32'h7FFF_FFFF);
        for (int i = 0; i < 12; i++) begin
            f = random_frame();
            f.imp_x = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
            f.imp_z = 24'sh7FFFFF;
            send_frame(f);
        end
    endtask

    // Receiver holds off for a long stretch while frames keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (600) @(negedge aclk);
                hold_output = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_frame(random_frame(), 1'b1);
        join
    endtask

    initial begin
        errors = 0;
        hold_output = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = ecms_pkg::CFG_DECEL;
        cfg_data = '0;
        decel = 6554; thresh = 66; plimit = 5440;
        pos[0] = 0; pos[1] = 0; pos[2] = 0;
        spd_x = 0; spd_z = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(350);
        test_backpressure();

        write_reg(ecms_pkg::CFG_DECEL, 32'h0000_FFFF);
        write_reg(ecms_pkg::CFG_THRESH, 32'h0000_0000);
        write_reg(ecms_pkg::CFG_PLIMIT, 32'd0);
        test_random(150);

        write_reg(ecms_pkg::CFG_DECEL, 32'h0000_0000);
        write_reg(ecms_pkg::CFG_THRESH, 32'h0000_FFFF);
        write_reg(ecms_pkg::CFG_PLIMIT, 32'd5760);
        test_random(150);

        write_reg(ecms_pkg::CFG_DECEL, 32'd300);
        write_reg(ecms_pkg::CFG_THRESH, 32'd500);
        write_reg(ecms_pkg::CFG_PLIMIT, 32'h0000_1FFF);
        test_saturation();

        write_reg(ecms_pkg::CFG_START_X, $urandom);
        write_reg(ecms_pkg::CFG_START_Y, $urandom);
        write_reg(ecms_pkg::CFG_START_Z, 32'h0);
        write_reg(ecms_pkg::CFG_DECEL, $urandom_range(0, 65535));
        write_reg(ecms_pkg::CFG_THRESH, $urandom_range(0, 2000));
        write_reg(ecms_pkg::CFG_PLIMIT, $urandom_range(0, 5760));
        test_random(450);

        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[euler_camera_motion_step_top.f]
rtl/ecms_pkg.sv
rtl/ecms_mul.sv
rtl/euler_camera_motion_step_top.sv
test/tb_top.sv
